### rtl/upd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg: shared types and constants of the URI percent decoder
// Request structs, the result group passed from front to back, mode codes
// and the hex digit decode.
// ----------------------------------------------------------------------------
package upd_pkg;

  // Result group queue depth
  localparam int unsigned QDEPTH = 4;

  localparam logic [7:0] PERCENT_CHAR = 8'h25;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_UTF8 = 3'd1,
    MODE_HEX1 = 3'd2,
    MODE_HEX2 = 3'd3,
    MODE_DROP = 3'd4
  } upd_mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } upd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_message;
    logic       error;
  } upd_out_t;

  // Up to four results caused by one input byte; cnt holds count minus one
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      cnt;
    logic            eom;
    logic            err;
  } upd_grp_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } upd_hex_t;

  // Decode one ASCII hex digit, either case
  function automatic upd_hex_t hex_decode(input logic [7:0] c);
    upd_hex_t r;
    r.ok  = 1'b1;
    r.nib = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nib = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.nib = c[3:0] + 4'd9;
    end else begin
      r.ok  = 1'b0;
      r.nib = 4'd0;
    end
    return r;
  endfunction

endpackage

### rtl/upd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_front: byte classifier
// Tracks escape and UTF-8 sequence state and turns each request into a
// group of zero to four results for the queue.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  upd_pkg::upd_in_t in_req_i,
  input  logic             space_i,
  output logic             push_o,
  output upd_pkg::upd_grp_t grp_o
);
  import upd_pkg::*;

  upd_mode_e  mode_q, mode_d;
  logic [1:0] held_q, held_d;
  logic [1:0] needed_q, needed_d;
  logic [3:0] nib_q, nib_d;
  logic [7:0] seq_q [3];
  logic       seq_we;
  logic [1:0] seq_idx;

  logic       accept;
  logic       err;
  logic [7:0] b;
  upd_hex_t   hx;
  upd_grp_t   grp;
  logic       emit;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i & space_i;
  assign b          = in_req_i.in_byte;
  assign hx         = hex_decode(b);

  // Classify the byte and build its result group
  always_comb begin
    mode_d   = mode_q;
    held_d   = held_q;
    needed_d = needed_q;
    nib_d    = nib_q;
    seq_we   = 1'b0;
    seq_idx  = held_q;
    err      = 1'b0;
    emit     = 1'b0;
    grp      = '0;
    grp.data = {b, b, b, b};

    unique case (mode_q)
      MODE_IDLE: begin
        if (b == PERCENT_CHAR) begin
          mode_d = MODE_HEX1;
        end else if (!b[7]) begin
          emit = 1'b1;
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
          seq_we   = 1'b1;
          seq_idx  = 2'd0;
          held_d   = 2'd1;
          needed_d = (b[7:5] == 3'b110) ? 2'd1 : (b[7:4] == 4'b1110) ? 2'd2 : 2'd3;
          mode_d   = MODE_UTF8;
        end else begin
          err = 1'b1;
        end
      end
      MODE_UTF8: begin
        if (b[7:6] != 2'b10) begin
          err = 1'b1;
        end else if (needed_q <= 2'd1) begin
          // Release the held sequence followed by this byte
          emit         = 1'b1;
          grp.cnt      = held_q;
          grp.data[0]  = seq_q[0];
          grp.data[1]  = (held_q >= 2'd2) ? seq_q[1] : b;
          grp.data[2]  = (held_q == 2'd3) ? seq_q[2] : b;
          held_d       = 2'd0;
          needed_d     = 2'd0;
          mode_d       = MODE_IDLE;
        end else begin
          if (held_q != 2'd3) begin
            seq_we = 1'b1;
            held_d = held_q + 2'd1;
          end
          needed_d = needed_q - 2'd1;
        end
      end
      MODE_HEX1: begin
        if (!hx.ok) begin
          err = 1'b1;
        end else begin
          nib_d  = hx.nib;
          mode_d = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        if (!hx.ok) begin
          err = 1'b1;
        end else begin
          emit        = 1'b1;
          grp.data[0] = {nib_q, hx.nib};
          mode_d      = MODE_IDLE;
        end
      end
      MODE_DROP: begin
      end
      default: begin
      end
    endcase

    // Flag a sequence or escape cut off by the last byte
    if (!err && in_req_i.last &&
        (mode_d == MODE_UTF8 || mode_d == MODE_HEX1 || mode_d == MODE_HEX2)) begin
      err = 1'b1;
    end

    if (err) begin
      emit     = 1'b1;
      grp      = '0;
      grp.err  = 1'b1;
      mode_d   = MODE_DROP;
      held_d   = 2'd0;
      needed_d = 2'd0;
      seq_we   = 1'b0;
    end

    if (in_req_i.last) begin
      grp.eom  = 1'b1;
      mode_d   = MODE_IDLE;
      held_d   = 2'd0;
      needed_d = 2'd0;
      nib_d    = 4'd0;
    end
  end

  assign push_o = accept & emit;
  assign grp_o  = grp;

  // Advance control state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      held_q   <= 2'd0;
      needed_q <= 2'd0;
      nib_q    <= 4'd0;
    end else if (accept) begin
      mode_q   <= mode_d;
      held_q   <= held_d;
      needed_q <= needed_d;
      nib_q    <= nib_d;
    end
  end

  // Hold bytes of an unfinished sequence
  always_ff @(posedge clk_i) begin
    if (accept && seq_we) begin
      seq_q[seq_idx] <= b;
    end
  end

  a_utf8_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_UTF8 |-> held_q != 2'd0 && needed_q != 2'd0)
    else $error("sequence mode with empty counters");

  a_drop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_DROP |-> held_q == 2'd0 && needed_q == 2'd0)
    else $error("drop mode with live counters");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && grp_o.err |-> grp_o.cnt == 2'd0 && grp_o.data == '0)
    else $error("error group not a single zero result");

endmodule

### rtl/upd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_fifo: result group queue
// Small register queue that decouples the classifier from the output side.
// ----------------------------------------------------------------------------
module upd_fifo #(
  parameter int unsigned Depth = upd_pkg::QDEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  upd_pkg::upd_grp_t wdata_i,
  output logic              space_o,
  input  logic              pop_i,
  output logic              avail_o,
  output upd_pkg::upd_grp_t rdata_o
);
  import upd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  upd_grp_t        mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign space_o = cnt_q != CntW'(Depth);
  assign avail_o = cnt_q != '0;
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store pushed groups
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/upd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_back: result serializer
// Holds one result group and hands out its bytes one per cycle while ready.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  upd_pkg::upd_grp_t grp_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output upd_pkg::upd_out_t out_req_o
);
  import upd_pkg::*;

  upd_grp_t   grp_q;
  logic [1:0] idx_q;
  logic       busy_q;
  logic       take;
  logic       done;

  assign take  = busy_q & out_ready_i;
  assign done  = take & (idx_q == grp_q.cnt);
  assign pop_o = avail_i & (!busy_q | done);

  assign out_valid_o              = busy_q;
  assign out_req_o.out_byte       = grp_q.data[idx_q];
  assign out_req_o.end_of_message = grp_q.eom & (idx_q == grp_q.cnt);
  assign out_req_o.error          = grp_q.err;

  // Advance through the group, load the next one when it is used up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (done) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  // Capture the group payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      grp_q <= grp_i;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= grp_q.cnt)
    else $error("result index past group size");

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !busy_q || (out_ready_i && idx_q == grp_q.cnt))
    else $error("group loaded over a live one");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.error |-> out_req_o.out_byte == 8'd0 &&
      idx_q == 2'd0)
    else $error("error result carries data");

endmodule

### rtl/uri_percent_decoder_utf8_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uri_percent_decoder_utf8_check: streaming percent decoder with UTF-8 check
// Decodes %XX escapes and passes UTF-8 sequences through once complete.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle while the group queue (QDepth entries) has room.
// The classifier turns each byte into zero to four results in the same
// cycle; the output side emits one result per cycle while out_ready_i is
// high, so the queue absorbs the burst from a byte that completes a
// four-byte sequence. A result is registered in the group queue, then in
// the serializer's group register. A malformed message yields a single
// error result and the rest of the message up to the last byte is dropped.
// ----------------------------------------------------------------------------
module uri_percent_decoder_utf8_check #(
  parameter int unsigned QDepth = upd_pkg::QDEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  upd_pkg::upd_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output upd_pkg::upd_out_t out_req_o
);
  import upd_pkg::*;

  upd_grp_t push_grp;
  upd_grp_t head_grp;
  logic     push;
  logic     pop;
  logic     space;
  logic     avail;

  // Classify incoming bytes
  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .space_i    (space),
    .push_o     (push),
    .grp_o      (push_grp)
  );

  // Buffer result groups
  upd_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_grp),
    .space_o (space),
    .pop_i   (pop),
    .avail_o (avail),
    .rdata_o (head_grp)
  );

  // Serialize results
  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .grp_i       (head_grp),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule
